// File: rtl/deq_pkg.sv
// Package for the double-ended queue: command and status codes and the
// control group broadcast to the storage cells. No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

	// Fixed field widths of a command beat and a response beat
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned INDEX_W  = 4;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_READ_IDX   = 3'd6,
		CMD_WRITE_IDX  = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Per-cycle control shared by every cell of the chain
	typedef struct packed {
		logic shift_r;  // push front: every cell takes its left neighbor
		logic shift_l;  // pop front: every cell takes its right neighbor
		logic load;     // the cell at the target position takes the value
	} cell_ctrl_t;

endpackage

// File: rtl/deq_if.sv
// Handshake interfaces for the command and response channels.
// Depends on deq_pkg for the fixed field widths.
`timescale 1ns / 1ps

interface deq_cmd_if #(
	parameter int DATA_WIDTH = 32
) ();
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::CMD_W-1:0]           command;
	logic signed [DATA_WIDTH-1:0]        value;
	logic [deq_pkg::INDEX_W-1:0]         index;

	modport source (output valid, command, value, index, input ready);
	modport sink   (input valid, command, value, index, output ready);
endinterface

interface deq_rsp_if #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5
) ();
	logic                                valid;
	logic                                ready;
	logic signed [DATA_WIDTH-1:0]        data;
	logic [CNT_W-1:0]                    count;
	logic [deq_pkg::STATUS_W-1:0]        status;

	modport source (output valid, data, count, status, input ready);
	modport sink   (input valid, data, count, status, output ready);
endinterface

// File: rtl/deq_cell.sv
// One storage cell of the queue chain: holds the element at a fixed logical
// position and trades data with its neighbors. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5,
	parameter int POS        = 0
) (
	input  logic                      clk,
	input  deq_pkg::cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0]          tgt_pos,
	input  logic [DATA_WIDTH-1:0]     value,
	input  logic [DATA_WIDTH-1:0]     left_data,
	input  logic [DATA_WIDTH-1:0]     right_data,
	output logic [DATA_WIDTH-1:0]     data
);

	logic [DATA_WIDTH-1:0] elem_q;
	logic                  here;

	assign here = (tgt_pos == CNT_W'(POS));

	// Shift toward the back, shift toward the front, or local write
	always_ff @(posedge clk) begin
		if (ctrl.shift_r) begin
			elem_q <= left_data;
		end else if (ctrl.shift_l) begin
			elem_q <= right_data;
		end else if (ctrl.load && here) begin
			elem_q <= value;
		end
	end

	assign data = elem_q;

endmodule

// File: rtl/double_ended_queue.sv
// Double-ended queue top level: control, cell chain and response register.
// Depends on deq_pkg, deq_cmd_if / deq_rsp_if and deq_cell.
//
// Usage:
//   cmd  : command beats (command, value, index), valid/ready handshake.
//   rsp  : one response beat per command (data, count, status).
//   Elements sit in a chain of DEPTH cells in logical order; cell 0 is the
//   front. Push front and pop front shift the whole chain by one cell at
//   once; push back and index writes load one cell in place.
//   The response is registered and appears in the cycle after the command is accepted.
//   Throughput: one command per cycle while the receiver takes responses; every command is a single
//   read-modify-write of the chain plus the count register.
//   The response register frees up in the cycle its beat is taken, so a
//   new command is accepted while the previous response is being consumed.
//   When the receiver stalls, cmd.ready drops and the pending response
//   holds. Reset empties the queue (count zero) and drops rsp.valid;
//   cell contents are not cleared and are never read before written.
//   data is zero for pushes, pops, index writes and failed commands.
`timescale 1ns / 1ps

module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	deq_cmd_if.sink   cmd,
	deq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > deq_pkg::INDEX_W) ? CNT_W : deq_pkg::INDEX_W;

	// Queue state
	logic [CNT_W-1:0]          count_q;

	// Response register
	logic                      rsp_valid_q;
	logic [DATA_WIDTH-1:0]     rsp_data_q;
	logic [CNT_W-1:0]          rsp_count_q;
	deq_pkg::status_t          rsp_status_q;

	// Control decode
	logic                      accept;
	logic                      full;
	logic                      empty;
	logic                      idx_ok;
	deq_pkg::cmd_t             op;
	deq_pkg::cell_ctrl_t       ctrl;
	deq_pkg::cell_ctrl_t       ctrl_gated;
	logic [CNT_W-1:0]          tgt_pos;
	logic [CNT_W-1:0]          rd_pos;
	logic                      rd_en;
	logic                      inc;
	logic                      dec;
	deq_pkg::status_t          status;
	logic [DATA_WIDTH-1:0]     rd_data;

	logic [DATA_WIDTH-1:0]     cell_data [DEPTH];

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign op     = deq_pkg::cmd_t'(cmd.command);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign idx_ok = (CMP_W'(cmd.index) < CMP_W'(count_q));

	// Command decode against the current state
	always_comb begin
		ctrl    = '0;
		tgt_pos = '0;
		rd_pos  = '0;
		rd_en   = 1'b0;
		inc     = 1'b0;
		dec     = 1'b0;
		status  = deq_pkg::ST_OK;
		unique case (op)
			deq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status = deq_pkg::ST_FULL;
				end else begin
					ctrl.load = 1'b1;
					tgt_pos   = count_q;
					inc       = 1'b1;
				end
			end
			deq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status = deq_pkg::ST_FULL;
				end else begin
					ctrl.shift_r = 1'b1;
					inc          = 1'b1;
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status = deq_pkg::ST_EMPTY;
				end else begin
					dec = 1'b1;
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status = deq_pkg::ST_EMPTY;
				end else begin
					ctrl.shift_l = 1'b1;
					dec          = 1'b1;
				end
			end
			deq_pkg::CMD_PEEK_FRONT: begin
				if (empty) begin
					status = deq_pkg::ST_EMPTY;
				end else begin
					rd_en = 1'b1;
				end
			end
			deq_pkg::CMD_PEEK_BACK: begin
				if (empty) begin
					status = deq_pkg::ST_EMPTY;
				end else begin
					rd_en  = 1'b1;
					rd_pos = count_q - CNT_W'(1);
				end
			end
			deq_pkg::CMD_READ_IDX: begin
				if (!idx_ok) begin
					status = deq_pkg::ST_RANGE;
				end else begin
					rd_en  = 1'b1;
					rd_pos = CNT_W'(CMP_W'(cmd.index));
				end
			end
			deq_pkg::CMD_WRITE_IDX: begin
				if (!idx_ok) begin
					status = deq_pkg::ST_RANGE;
				end else begin
					ctrl.load = 1'b1;
					tgt_pos   = CNT_W'(CMP_W'(cmd.index));
				end
			end
			default: begin
				status = deq_pkg::ST_OK;
			end
		endcase
	end

	assign ctrl_gated = accept ? ctrl : '0;

	// Cell chain; cell 0 takes the new value on a front push
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = cmd.value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		deq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.POS        (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl_gated),
			.tgt_pos    (tgt_pos),
			.value      (cmd.value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	// Read select: AND-OR over the cells
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rd_pos == CNT_W'(i)) begin
				rd_data = rd_data | cell_data[i];
			end
		end
		if (!rd_en) begin
			rd_data = '0;
		end
	end

	// Element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (dec) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q   <= rd_data;
			rsp_status_q <= status;
			if (inc) begin
				rsp_count_q <= count_q + CNT_W'(1);
			end else if (dec) begin
				rsp_count_q <= count_q - CNT_W'(1);
			end else begin
				rsp_count_q <= count_q;
			end
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.count  = rsp_count_q;
	assign rsp.status = rsp_status_q;

endmodule

// File: dv/deq_scoreboard.sv
// Self-checking monitor for the double-ended queue: keeps its own ring-buffer copy
// of the queue, predicts one response per accepted command beat and compares it field by field.
// Depends on deq_pkg and the deq_cmd_if / deq_rsp_if interfaces.
`timescale 1ns / 1ps

module deq_scoreboard #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	deq_cmd_if                           cmd,
	deq_rsp_if                           rsp,
	output int                           mismatches,
	output int                           outstanding,
	output int                           responses,
	output int                           full_seen,
	output int                           empty_seen,
	output int                           range_seen,
	output logic [$clog2(DEPTH+1)-1:0]   occupancy
);

	localparam int SLOT_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int EXP_DEPTH = 16;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] data;
		logic [CNT_W-1:0]             count;
		deq_pkg::status_t             status;
	} deq_result_t;

	// Mirror of the queue contents, front slot and element count
	logic signed [DATA_WIDTH-1:0] ring [DEPTH];
	logic [SLOT_W-1:0]            front_slot;
	logic [CNT_W-1:0]             held;

	// Predicted responses in command order; head and tail count beats
	deq_result_t                  expected_q [EXP_DEPTH];
	int                           exp_head;
	int                           exp_tail;

	assign occupancy = held;

	function automatic int slot_at(int pos);
		return (int'(front_slot) + pos) % DEPTH;
	endfunction

	// Apply one command to the mirror and return the response it must produce
	function automatic deq_result_t apply_command(deq_pkg::cmd_t op,
			logic signed [DATA_WIDTH-1:0] val, logic [deq_pkg::INDEX_W-1:0] idx);
		deq_result_t r;
		r.data   = '0;
		r.status = deq_pkg::ST_OK;
		case (op)
			deq_pkg::CMD_PUSH_BACK: begin
				if (held == DEPTH) r.status = deq_pkg::ST_FULL;
				else begin
					ring[slot_at(int'(held))] = val;
					held++;
				end
			end
			deq_pkg::CMD_PUSH_FRONT: begin
				if (held == DEPTH) r.status = deq_pkg::ST_FULL;
				else begin
					front_slot = SLOT_W'((int'(front_slot) + DEPTH - 1) % DEPTH);
					ring[front_slot] = val;
					held++;
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (held == 0) r.status = deq_pkg::ST_EMPTY;
				else held--;
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (held == 0) r.status = deq_pkg::ST_EMPTY;
				else begin
					front_slot = SLOT_W'(slot_at(1));
					held--;
				end
			end
			deq_pkg::CMD_PEEK_FRONT: begin
				if (held == 0) r.status = deq_pkg::ST_EMPTY;
				else r.data = ring[front_slot];
			end
			deq_pkg::CMD_PEEK_BACK: begin
				if (held == 0) r.status = deq_pkg::ST_EMPTY;
				else r.data = ring[slot_at(int'(held) - 1)];
			end
			deq_pkg::CMD_READ_IDX: begin
				if (idx >= held) r.status = deq_pkg::ST_RANGE;
				else r.data = ring[slot_at(int'(idx))];
			end
			default: begin
				// write at a logical index
				if (idx >= held) r.status = deq_pkg::ST_RANGE;
				else ring[slot_at(int'(idx))] = val;
			end
		endcase
		r.count = held;
		return r;
	endfunction

	// Check response beats first, then queue the prediction for a new command beat
	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		if (!arst_n) begin
			exp_head    = 0;
			exp_tail    = 0;
			front_slot  = '0;
			held        = '0;
			mismatches  = 0;
			outstanding = 0;
			responses   = 0;
			full_seen   = 0;
			empty_seen  = 0;
			range_seen  = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				responses++;
				if (exp_tail == exp_head) begin
					mismatches++;
					$display("%0t: response beat with none expected: data %h count %0d status %0d",
						$time, rsp.data, rsp.count, rsp.status);
				end else begin
					want = expected_q[exp_head % EXP_DEPTH];
					exp_head++;
					case (want.status)
						deq_pkg::ST_FULL:  full_seen++;
						deq_pkg::ST_EMPTY: empty_seen++;
						deq_pkg::ST_RANGE: range_seen++;
						default: ;
					endcase
					if (rsp.data !== want.data || rsp.count !== want.count
							|| rsp.status !== want.status) begin
						mismatches++;
						if (rsp.data !== want.data)
							$display("%0t: data mismatch: expected %h, actual %h",
								$time, want.data, rsp.data);
						if (rsp.count !== want.count)
							$display("%0t: count mismatch: expected %0d, actual %0d",
								$time, want.count, rsp.count);
						if (rsp.status !== want.status)
							$display("%0t: status mismatch: expected %s, actual %0d",
								$time, want.status.name(), rsp.status);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				if (exp_tail - exp_head >= EXP_DEPTH) begin
					mismatches++;
					$display("%0t: command beat accepted with %0d responses still owed",
						$time, exp_tail - exp_head);
				end else begin
					expected_q[exp_tail % EXP_DEPTH] = apply_command(
						deq_pkg::cmd_t'(cmd.command), cmd.value, cmd.index);
					exp_tail++;
				end
			end
			outstanding = exp_tail - exp_head;
		end
	end

endmodule

// File: dv/double_ended_queue_test.sv
// Testbench top for double_ended_queue: directed corner commands, then random
// fill/drain/mixed phases with random gaps and response stalls; deq_scoreboard checks.
// Depends on deq_pkg, deq_if.sv, double_ended_queue and deq_scoreboard.
`timescale 1ns / 1ps

module double_ended_queue_test;

	localparam int DEPTH        = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int RANDOM_BEATS = 1850;
	localparam int IDX_W        = deq_pkg::INDEX_W;
	localparam int CNT_W        = $clog2(DEPTH + 1);

	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIX   = 2;

	logic clk;
	logic arst_n;
	bit   burst_mode;
	int   sent;
	int   directed_sent;

	int   mismatches, outstanding, responses, full_seen, empty_seen, range_seen;
	logic [CNT_W-1:0] model_held;

	deq_cmd_if #(.DATA_WIDTH(DATA_WIDTH)) cmd_ch ();
	deq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .CNT_W(CNT_W)) rsp_ch ();

	double_ended_queue #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	deq_scoreboard #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.responses   (responses),
		.full_seen   (full_seen),
		.empty_seen  (empty_seen),
		.range_seen  (range_seen),
		.occupancy   (model_held)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Drive one command beat after a random gap (none in burst mode); returns at the falling edge after acceptance
	task automatic send_beat(input deq_pkg::cmd_t op, input logic signed [DATA_WIDTH-1:0] val,
			input logic [IDX_W-1:0] idx);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.command <= op;
		cmd_ch.value   <= val;
		cmd_ch.index   <= idx;
		cmd_ch.valid   <= 1'b1;
		@(posedge clk);
		while (!(cmd_ch.valid && cmd_ch.ready)) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Hold off the sender until every response is back
	task automatic drain_responses();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Response side: random stall before each beat (none in burst mode), ready held until one is taken
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = burst_mode ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
			@(negedge clk);
		end
	end

	// Stimulus
	initial begin
		int                           mode, seg_len, r;
		bit                           paused_mid;
		deq_pkg::cmd_t                op;
		logic signed [DATA_WIDTH-1:0] val;
		logic [IDX_W-1:0]             idx;

		arst_n         = 1'b0;
		burst_mode     = 1'b0;
		sent           = 0;
		paused_mid     = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = deq_pkg::CMD_PUSH_BACK;
		cmd_ch.value   = '0;
		cmd_ch.index   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every command but push front on the empty queue, extreme values, index bounds
		send_beat(deq_pkg::CMD_POP_BACK,   $urandom, 4'd0);
		send_beat(deq_pkg::CMD_POP_FRONT,  $urandom, 4'd0);
		send_beat(deq_pkg::CMD_PEEK_FRONT, $urandom, 4'd0);
		send_beat(deq_pkg::CMD_PEEK_BACK,  $urandom, 4'd0);
		send_beat(deq_pkg::CMD_READ_IDX,   $urandom, 4'd0);
		send_beat(deq_pkg::CMD_WRITE_IDX,  32'h1234_5678, 4'd15);
		send_beat(deq_pkg::CMD_PUSH_BACK,  32'h8000_0000, 4'd0);
		send_beat(deq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff, 4'd0);
		send_beat(deq_pkg::CMD_PUSH_BACK,  32'hffff_ffff, 4'd0);
		send_beat(deq_pkg::CMD_PUSH_FRONT, 32'h0000_0000, 4'd0);
		send_beat(deq_pkg::CMD_PEEK_FRONT, $urandom, 4'd0);
		send_beat(deq_pkg::CMD_PEEK_BACK,  $urandom, 4'd0);
		send_beat(deq_pkg::CMD_READ_IDX,   $urandom, 4'd0);
		send_beat(deq_pkg::CMD_READ_IDX,   $urandom, 4'd3);
		send_beat(deq_pkg::CMD_READ_IDX,   $urandom, 4'd4);
		send_beat(deq_pkg::CMD_WRITE_IDX,  32'h5555_5555, 4'd2);
		send_beat(deq_pkg::CMD_READ_IDX,   $urandom, 4'd2);
		send_beat(deq_pkg::CMD_WRITE_IDX,  32'haaaa_aaaa, 4'd15);
		send_beat(deq_pkg::CMD_POP_BACK,   $urandom, 4'd0);
		send_beat(deq_pkg::CMD_POP_FRONT,  $urandom, 4'd0);
		send_beat(deq_pkg::CMD_PEEK_BACK,  $urandom, 4'd0);
		send_beat(deq_pkg::CMD_POP_FRONT,  $urandom, 4'd0);
		send_beat(deq_pkg::CMD_POP_BACK,   $urandom, 4'd0);
		send_beat(deq_pkg::CMD_POP_BACK,   $urandom, 4'd0);
		directed_sent = sent;
		drain_responses();

		// Random phases: fill-heavy runs drive toward full, drain-heavy runs toward empty
		while (sent - directed_sent < RANDOM_BEATS) begin
			if (!paused_mid && sent - directed_sent >= RANDOM_BEATS / 2) begin
				paused_mid = 1'b1;
				drain_responses();
			end
			mode       = $urandom_range(MODE_FILL, MODE_MIX);
			seg_len    = $urandom_range(15, 60);
			burst_mode = ($urandom_range(0, 3) == 0);
			repeat (seg_len) begin
				r = $urandom_range(0, 99);
				case (mode)
					MODE_FILL:
						if (r < 60) op = deq_pkg::cmd_t'($urandom_range(0, 1));
						else if (r < 75) op = deq_pkg::cmd_t'($urandom_range(2, 3));
						else op = deq_pkg::cmd_t'($urandom_range(4, 7));
					MODE_DRAIN:
						if (r < 60) op = deq_pkg::cmd_t'($urandom_range(2, 3));
						else if (r < 75) op = deq_pkg::cmd_t'($urandom_range(0, 1));
						else op = deq_pkg::cmd_t'($urandom_range(4, 7));
					default:
						op = deq_pkg::cmd_t'($urandom_range(0, 7));
				endcase
				case ($urandom_range(0, 19))
					0:       val = 32'h8000_0000;
					1:       val = 32'h7fff_ffff;
					2:       val = 32'hffff_ffff;
					3:       val = 32'h0000_0000;
					default: val = $urandom;
				endcase
				// mostly live positions, sometimes anywhere in the index range
				if (model_held != 0 && $urandom_range(0, 9) < 7)
					idx = IDX_W'($urandom_range(0, model_held - 1));
				else
					idx = IDX_W'($urandom_range(0, 15));
				send_beat(op, val, idx);
			end
		end
		burst_mode = 1'b0;

		// Wind down
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(negedge clk);

		$display("Commands sent: %0d directed, %0d random; responses checked: %0d",
			directed_sent, sent - directed_sent, responses);
		$display("Rejected beats seen: %0d full, %0d empty, %0d index out of range",
			full_seen, empty_seen, range_seen);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: double_ended_queue.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
dv/deq_scoreboard.sv
dv/double_ended_queue_test.sv
